>>> rtl/apt_pkg.sv
// ---------------------------------------------------------------------------
// apt_pkg: accidental pitch tracker shared types and constants
// Accidental codes, decoded request struct, key signature and letter tables.
// ---------------------------------------------------------------------------
package apt_pkg;

    typedef enum logic [1:0] {
        ACC_NONE    = 2'd0,
        ACC_SHARP   = 2'd1,
        ACC_FLAT    = 2'd2,
        ACC_NATURAL = 2'd3
    } acc_t;

    localparam logic [3:0] OCT_OFFSET    = 4'd4;
    localparam logic [3:0] OCT_MAX       = 4'd9;
    localparam logic [7:0] SEMIS_PER_OCT = 8'd12;
    localparam logic [2:0] LETTER_MAX    = 3'd6;
    localparam logic [1:0] KEY_MULT      = 2'd1;

    typedef struct packed {
        logic       is_bar;
        logic       is_note;
        logic [2:0] letter;
        acc_t       acc;
        logic [1:0] mult;
        logic [3:0] oct;
    } dec_t;

    typedef struct packed {
        acc_t       acc;
        logic [1:0] mult;
    } line_ent_t;

    function automatic logic [3:0] letter_semis(input logic [2:0] letter);
        logic [3:0] s;
        unique case (letter)
            3'd0:    s = 4'd0;
            3'd1:    s = 4'd2;
            3'd2:    s = 4'd4;
            3'd3:    s = 4'd5;
            3'd4:    s = 4'd7;
            3'd5:    s = 4'd9;
            3'd6:    s = 4'd11;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    // position of the letter in the order of sharps (F C G D A E B)
    function automatic logic [3:0] sharp_pos(input logic [2:0] letter);
        logic [3:0] p;
        unique case (letter)
            3'd0:    p = 4'd1;
            3'd1:    p = 4'd3;
            3'd2:    p = 4'd5;
            3'd3:    p = 4'd0;
            3'd4:    p = 4'd2;
            3'd5:    p = 4'd4;
            3'd6:    p = 4'd6;
            default: p = 4'd7;
        endcase
        return p;
    endfunction

    // position of the letter in the order of flats (B E A D G C F)
    function automatic logic [3:0] flat_pos(input logic [2:0] letter);
        logic [3:0] p;
        unique case (letter)
            3'd0:    p = 4'd5;
            3'd1:    p = 4'd3;
            3'd2:    p = 4'd1;
            3'd3:    p = 4'd6;
            3'd4:    p = 4'd4;
            3'd5:    p = 4'd2;
            3'd6:    p = 4'd0;
            default: p = 4'd7;
        endcase
        return p;
    endfunction

    function automatic acc_t key_accidental(input logic signed [3:0] key,
                                            input logic [2:0] letter);
        logic signed [4:0] k;
        logic signed [4:0] ps;
        logic signed [4:0] pf;
        acc_t a;
        k  = {key[3], key};
        ps = $signed({1'b0, sharp_pos(letter)});
        pf = $signed({1'b0, flat_pos(letter)});
        if (k > ps) begin
            a = ACC_SHARP;
        end else if (k < -pf) begin
            a = ACC_FLAT;
        end else begin
            a = ACC_NONE;
        end
        return a;
    endfunction

endpackage

>>> rtl/apt_ram.sv
// ---------------------------------------------------------------------------
// apt_ram: generic single-port-write RAM with registered read
// One write and one read port; read data updates only on read enable.
// ---------------------------------------------------------------------------
module apt_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 70
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/apt_decode.sv
// ---------------------------------------------------------------------------
// apt_decode: request decode and stave line index
// Offsets and clamps the octave, classifies the request, forms the line index.
// ---------------------------------------------------------------------------
module apt_decode
    import apt_pkg::*;
#(
    parameter int NOTE_LINES = 70
) (
    input  logic                          mode,
    input  logic [2:0]                    note_letter,
    input  logic [1:0]                    accidental,
    input  logic [1:0]                    multiplier,
    input  logic signed [3:0]             octave,
    output dec_t                          dec,
    output logic [$clog2(NOTE_LINES)-1:0] line
);

    localparam int LINE_W = $clog2(NOTE_LINES);
    localparam int CALC_W = (LINE_W > 7) ? LINE_W : 7;

    logic signed [4:0] oct_off;
    logic [3:0]        oct_clamp;
    logic [CALC_W-1:0] raw_line;
    logic [CALC_W-1:0] sel_line;

    always_comb begin
        oct_off = $signed({octave[3], octave}) + $signed({1'b0, OCT_OFFSET});
        if (oct_off < 0) begin
            oct_clamp = 4'd0;
        end else if (oct_off > $signed({1'b0, OCT_MAX})) begin
            oct_clamp = OCT_MAX;
        end else begin
            oct_clamp = oct_off[3:0];
        end
        raw_line = (CALC_W'(oct_clamp) << 3) - CALC_W'(oct_clamp) + CALC_W'(note_letter);
        sel_line = (raw_line < CALC_W'(NOTE_LINES)) ? raw_line : '0;
    end

    assign line        = sel_line[LINE_W-1:0];
    assign dec.is_bar  = mode;
    assign dec.is_note = !mode && (note_letter <= LETTER_MAX);
    assign dec.letter  = note_letter;
    assign dec.acc     = acc_t'(accidental);
    assign dec.mult    = multiplier;
    assign dec.oct     = oct_clamp;

endmodule

>>> rtl/apt_resolve.sv
// ---------------------------------------------------------------------------
// apt_resolve: accidental selection and pitch computation
// Picks explicit, remembered or key accidental and forms the semitone pitch.
// ---------------------------------------------------------------------------
module apt_resolve
    import apt_pkg::*;
(
    input  dec_t              item,
    input  line_ent_t         stored,
    input  logic              stored_vld,
    input  logic signed [3:0] key,
    output logic signed [7:0] pitch
);

    acc_t       eff_acc;
    logic [1:0] eff_mult;
    logic [7:0] base;

    always_comb begin
        if (item.acc != ACC_NONE) begin
            eff_acc  = item.acc;
            eff_mult = item.mult;
        end else if (stored_vld && stored.acc != ACC_NONE) begin
            eff_acc  = stored.acc;
            eff_mult = stored.mult;
        end else begin
            eff_acc  = key_accidental(key, item.letter);
            eff_mult = KEY_MULT;
        end

        base = 8'(item.oct) * SEMIS_PER_OCT + 8'(letter_semis(item.letter));

        case (eff_acc)
            ACC_SHARP: pitch = $signed(base + {6'd0, eff_mult});
            ACC_FLAT:  pitch = $signed(base - {6'd0, eff_mult});
            default:   pitch = $signed(base);
        endcase
    end

endmodule

>>> rtl/accidental_pitch_tracker_top.sv
// ---------------------------------------------------------------------------
// accidental_pitch_tracker_top: note stream to absolute semitone pitch
// Tracks per-line accidentals within a bar and applies the key signature.
// ---------------------------------------------------------------------------
// Takes one request per cycle while the output is not stalled, and delivers
// a note's pitch through decode and line-memory read at the accepting edge,
// then resolve into the result register once the output is free. Bar lines
// and notes with letter code 7 give no result. Remembered accidentals sit in
// a NOTE_LINES-entry RAM with one valid flop per line; a bar line clears all
// flags at once, so there is no clearing pass after reset. A note that
// immediately follows a note on the same line sees its accidental through a
// bypass register. The key signature is written through cfg_wr_en/cfg_wr_data
// by the user only while idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module accidental_pitch_tracker_top
    import apt_pkg::*;
#(
    parameter int NOTE_LINES = 70
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic signed [3:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_mode,
    input  logic [2:0]        s_note_letter,
    input  logic [1:0]        s_accidental,
    input  logic [1:0]        s_multiplier,
    input  logic signed [3:0] s_octave,
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [7:0] m_pitch_semitones
);

    localparam int LINE_W = $clog2(NOTE_LINES);
    localparam int ENT_W  = $bits(line_ent_t);

    logic signed [3:0]  key_reg;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    dec_t               s1_item_reg;
    logic [LINE_W-1:0]  s1_line_reg;
    logic               byp_hit_reg;
    logic               byp_hit_next;
    line_ent_t          byp_data_reg;
    logic [NOTE_LINES-1:0] line_vld_reg;
    logic [NOTE_LINES-1:0] line_vld_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic signed [7:0]  pitch_reg;

    dec_t               dec;
    logic [LINE_W-1:0]  dec_line;
    logic               out_free;
    logic               s1_adv;
    logic               s_fire;
    logic               wr_en;
    line_ent_t          wr_ent;
    logic [ENT_W-1:0]   rd_data;
    line_ent_t          stored;
    logic               stored_vld;
    logic signed [7:0]  pitch;

    apt_decode #(
        .NOTE_LINES (NOTE_LINES)
    ) u_decode (
        .mode        (s_mode),
        .note_letter (s_note_letter),
        .accidental  (s_accidental),
        .multiplier  (s_multiplier),
        .octave      (s_octave),
        .dec         (dec),
        .line        (dec_line)
    );

    apt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NOTE_LINES)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s1_line_reg),
        .wr_data (wr_ent),
        .rd_en   (s_fire),
        .rd_addr (dec_line),
        .rd_data (rd_data)
    );

    apt_resolve u_resolve (
        .item       (s1_item_reg),
        .stored     (stored),
        .stored_vld (stored_vld),
        .key        (key_reg),
        .pitch      (pitch)
    );

    always_comb begin
        out_free     = !m_valid_reg || m_ready;
        s1_adv       = s1_valid_reg && out_free;
        s_ready      = !s1_valid_reg || out_free;
        s_fire       = s_valid && s_ready;

        wr_en        = s1_adv && s1_item_reg.is_note && (s1_item_reg.acc != ACC_NONE);
        wr_ent.acc   = s1_item_reg.acc;
        wr_ent.mult  = s1_item_reg.mult;

        byp_hit_next = wr_en && (s1_line_reg == dec_line);

        stored       = byp_hit_reg ? byp_data_reg : line_ent_t'(rd_data);
        stored_vld   = byp_hit_reg || line_vld_reg[s1_line_reg];

        if (s_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        line_vld_next = line_vld_reg;
        if (s1_adv && s1_item_reg.is_bar) begin
            line_vld_next = '0;
        end else if (wr_en) begin
            line_vld_next[s1_line_reg] = 1'b1;
        end

        if (s1_adv) begin
            m_valid_next = s1_item_reg.is_note;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg      <= '0;
            s1_valid_reg <= 1'b0;
            line_vld_reg <= '0;
            m_valid_reg  <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                key_reg <= cfg_wr_data;
            end
            s1_valid_reg <= s1_valid_next;
            line_vld_reg <= line_vld_next;
            m_valid_reg  <= m_valid_next;
            if (s_fire) begin
                byp_hit_reg <= byp_hit_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_item_reg  <= dec;
            s1_line_reg  <= dec_line;
            byp_data_reg <= wr_ent;
        end
        if (s1_adv) begin
            pitch_reg <= pitch;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_pitch_semitones = pitch_reg;

endmodule
